// File: sv/clsg_pkg.sv
// ----------------------------------------------------------------------------
// clsg_pkg
// Constants, control word and microcode program of the combined LCG
// shuffle generator.
// ----------------------------------------------------------------------------
package clsg_pkg;

	localparam int VAL_W  = 31;
	localparam int FRAC_W = 24;
	localparam int UPC_W  = 4;
	localparam int WARMUP_EXTRA = 8;

	localparam logic [VAL_W-1:0] MOD_A          = 31'd2147483563;
	localparam logic [VAL_W-1:0] MOD_B          = 31'd2147483399;
	localparam logic [VAL_W-1:0] MOD_A_LESS_ONE = 31'd2147483562;
	localparam logic [VAL_W-1:0] GEN_A_INIT     = 31'd1;
	localparam logic [VAL_W-1:0] GEN_B_INIT     = 31'd123456789;
	localparam logic [15:0]      MUL_A          = 16'd40014;
	localparam logic [15:0]      MUL_B          = 16'd40692;
	// 2^31 - modulus, used to fold the high product bits back in
	localparam logic [7:0]       FOLD_A         = 8'd85;
	localparam logic [7:0]       FOLD_B         = 8'd249;

	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UPC_IDLE       = 4'd0;
	localparam upc_t UPC_SEED       = 4'd1;
	localparam upc_t UPC_WARM_MUL   = 4'd2;
	localparam upc_t UPC_WARM_RED   = 4'd3;
	localparam upc_t UPC_DRAW_MUL_A = 4'd4;
	localparam upc_t UPC_DRAW_MUL_B = 4'd5;
	localparam upc_t UPC_DRAW_READ  = 4'd6;
	localparam upc_t UPC_DRAW_MIX   = 4'd7;
	localparam upc_t UPC_DRAW_EMIT  = 4'd8;

	typedef enum logic [1:0] {
		SEQ_NEXT   = 2'd0,
		SEQ_ACCEPT = 2'd1,
		SEQ_LOOP   = 2'd2,
		SEQ_EMIT   = 2'd3
	} seq_t;

	typedef struct packed {
		seq_t seq;
		upc_t target;
		logic mul_go;
		logic mul_b;
		logic wr_x;
		logic wr_y;
		logic seed;
		logic cnt_load;
		logic fill;
		logic ram_rd;
		logic mix;
		logic emit;
	} ctl_t;

	function automatic ctl_t ucode(input upc_t upc);
		ctl_t c;
		c = '0;
		c.seq = SEQ_NEXT;
		c.target = UPC_IDLE;
		unique case (upc)
			UPC_IDLE: begin
				c.seq = SEQ_ACCEPT;
				c.target = UPC_DRAW_MUL_A;
			end
			UPC_SEED: begin
				c.seed = 1'b1;
				c.cnt_load = 1'b1;
			end
			UPC_WARM_MUL: begin
				c.mul_go = 1'b1;
			end
			UPC_WARM_RED: begin
				c.wr_x = 1'b1;
				c.fill = 1'b1;
				c.seq = SEQ_LOOP;
				c.target = UPC_WARM_MUL;
			end
			UPC_DRAW_MUL_A: begin
				c.mul_go = 1'b1;
			end
			UPC_DRAW_MUL_B: begin
				c.wr_x = 1'b1;
				c.mul_go = 1'b1;
				c.mul_b = 1'b1;
			end
			UPC_DRAW_READ: begin
				c.wr_y = 1'b1;
				c.ram_rd = 1'b1;
			end
			UPC_DRAW_MIX: begin
				c.mix = 1'b1;
			end
			UPC_DRAW_EMIT: begin
				c.emit = 1'b1;
				c.seq = SEQ_EMIT;
				c.target = UPC_IDLE;
			end
			default: begin
				c.seq = SEQ_EMIT;
				c.target = UPC_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// File: sv/clsg_if.sv
// ----------------------------------------------------------------------------
// clsg_if
// Request and result channels of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
interface clsg_req_if;
	import clsg_pkg::*;
	logic             valid;
	logic             ready;
	logic             operation;
	logic [VAL_W-1:0] seed_magnitude;
	modport source (output valid, output operation, output seed_magnitude, input ready);
	modport sink   (input valid, input operation, input seed_magnitude, output ready);
endinterface

interface clsg_res_if;
	import clsg_pkg::*;
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  random_value;
	logic [FRAC_W-1:0] fraction;
	modport source (output valid, output random_value, output fraction, input ready);
	modport sink   (input valid, input random_value, input fraction, output ready);
endinterface

// File: sv/clsg_ram.sv
// ----------------------------------------------------------------------------
// clsg_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module clsg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/combined_lcg_shuffle_generator.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_generator
// Two multiplicative congruential generators combined through a shuffle
// table, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | accepted when
//  req     | in  | operation, seed_magnitude        | req.valid & req.ready
//  res     | out | random_value, fraction (Q0.24)   | res.valid & res.ready
//
//  Draw: one shared 31x16 mulmod for two generator steps in turn, one table
//  read and one table write.
//  Reseed: 40 warm-up steps through the mulmod.
//  Table valid bits clear at reset, no clearing pass.
//  Result sits in an output register; the sequencer holds its last step only
//  while an earlier result is still untaken.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_generator #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	clsg_req_if.sink   req,
	clsg_res_if.source res
);
	import clsg_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
	localparam logic [NW-1:0] WARM_LAST  = NW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
	localparam logic [NW-1:0] FILL_LIMIT = NW'(TABLE_DEPTH);

	localparam logic [31:0] SLOT_SPAN = 32'(1 + 2147483562 / TABLE_DEPTH);
	localparam int SPAN_BITS   = $clog2(SLOT_SPAN);
	localparam int RECIP_SHIFT = 31 + SPAN_BITS;
	localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / {32'd0, SLOT_SPAN};
	localparam logic [31:0] RECIP = RECIP_FULL[31:0];
	localparam int SLOT_QW = $clog2(TABLE_DEPTH) + 2;
	localparam logic [SLOT_QW-1:0] SLOT_MAX = SLOT_QW'(TABLE_DEPTH - 1);

	// sequencer
	upc_t            upc_q;
	logic [NW-1:0]   n_q;
	ctl_t            ctl;
	logic            req_fire;
	logic            res_load;

	// datapath
	logic [VAL_W-1:0]  x_q, y_q, out_q, seed_q;
	logic [46:0]       prod_q;
	logic              prod_b_q;
	logic [VAL_W-1:0]  mul_op;
	logic [15:0]       mul_k;
	logic [15:0]       red_hi;
	logic [7:0]        red_fold;
	logic [VAL_W-1:0]  red_mod;
	logic [31:0]       red_sum;
	logic [VAL_W-1:0]  red_val;
	logic [VAL_W-1:0]  seed_nz, seed_a, seed_b;

	// slot index
	logic [62:0]        slot_prod_s1;
	logic [VAL_W-1:0]   slot_val_s1;
	logic [SLOT_QW-1:0] slot_est, slot_inc, slot_fix;
	logic [SLOT_QW+31:0] slot_bound;
	logic [AW-1:0]      slot_q;

	// table
	logic [TABLE_DEPTH-1:0] vld_q;
	logic                   rd_vld_q;
	logic                   fill_hit;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [VAL_W-1:0]       ram_wdata;
	logic [VAL_W-1:0]       ram_rdata;
	logic [VAL_W-1:0]       mix_tab;
	logic signed [32:0]     mix_diff, mix_wrap;
	logic [VAL_W-1:0]       mix_val;

	// fraction and result
	logic [FRAC_W-1:0] frac_q0, frac_val;
	logic [32:0]       frac_rem;
	logic              res_valid_q;
	logic [VAL_W-1:0]  res_value_q;
	logic [FRAC_W-1:0] res_frac_q;

	// ---------------- sequencer ----------------
	assign ctl       = ucode(upc_q);
	assign req.ready = (ctl.seq == SEQ_ACCEPT);
	assign req_fire  = req.valid && req.ready;
	assign res_load  = ctl.emit && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
			n_q   <= '0;
		end else begin
			unique case (ctl.seq)
				SEQ_NEXT: upc_q <= upc_q + 1'b1;
				SEQ_ACCEPT: begin
					if (req_fire) begin
						upc_q <= req.operation ? upc_q + 1'b1 : ctl.target;
					end
				end
				SEQ_LOOP: upc_q <= (n_q != '0) ? ctl.target : upc_q + 1'b1;
				SEQ_EMIT: begin
					if (res_load) begin
						upc_q <= ctl.target;
					end
				end
				default: upc_q <= UPC_IDLE;
			endcase
			if (ctl.cnt_load) begin
				n_q <= WARM_LAST;
			end else if (ctl.seq == SEQ_LOOP) begin
				n_q <= n_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			seed_q <= req.seed_magnitude;
		end
	end

	// ---------------- modular multiplier ----------------
	assign mul_op = ctl.mul_b ? y_q : x_q;
	assign mul_k  = ctl.mul_b ? MUL_B : MUL_A;

	always_ff @(posedge clk) begin
		if (ctl.mul_go) begin
			prod_q   <= 47'(mul_op) * 47'(mul_k);
			prod_b_q <= ctl.mul_b;
		end
	end

	assign red_hi   = prod_q[46:31];
	assign red_fold = prod_b_q ? FOLD_B : FOLD_A;
	assign red_mod  = prod_b_q ? MOD_B : MOD_A;
	assign red_sum  = {1'b0, prod_q[30:0]} + 32'(red_hi) * 32'(red_fold);
	assign red_val  = (red_sum >= {1'b0, red_mod}) ? 31'(red_sum - {1'b0, red_mod})
	                                               : red_sum[30:0];

	assign seed_nz = (seed_q == '0) ? 31'd1 : seed_q;
	assign seed_a  = (seed_nz >= MOD_A) ? seed_nz - MOD_A : seed_nz;
	assign seed_b  = (seed_nz >= MOD_B) ? seed_nz - MOD_B : seed_nz;

	assign fill_hit = ctl.fill && (n_q < FILL_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= GEN_A_INIT;
			y_q   <= GEN_B_INIT;
			out_q <= '0;
		end else begin
			if (ctl.seed) begin
				x_q <= seed_a;
				y_q <= seed_b;
			end else begin
				if (ctl.wr_x) begin
					x_q <= red_val;
				end
				if (ctl.wr_y) begin
					y_q <= red_val;
				end
			end
			if (fill_hit && (n_q == '0)) begin
				out_q <= red_val;
			end else if (ctl.mix) begin
				out_q <= mix_val;
			end
		end
	end

	// ---------------- slot index, out_q / SLOT_SPAN ----------------
	always_ff @(posedge clk) begin
		slot_prod_s1 <= 63'(out_q) * 63'(RECIP);
		slot_val_s1  <= out_q;
		slot_q       <= slot_fix[AW-1:0];
	end

	always_comb begin
		slot_est   = SLOT_QW'(slot_prod_s1 >> RECIP_SHIFT);
		slot_inc   = slot_est + 1'b1;
		slot_bound = (SLOT_QW+32)'(slot_inc) * (SLOT_QW+32)'(SLOT_SPAN);
		slot_fix   = ((SLOT_QW+32)'(slot_val_s1) >= slot_bound) ? slot_inc : slot_est;
		if (slot_fix > SLOT_MAX) begin
			slot_fix = SLOT_MAX;
		end
	end

	// ---------------- shuffle table ----------------
	assign ram_we    = fill_hit || ctl.mix;
	assign ram_waddr = ctl.mix ? slot_q : n_q[AW-1:0];
	assign ram_wdata = ctl.mix ? x_q : red_val;

	clsg_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.ram_rd),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (ctl.ram_rd) begin
				rd_vld_q <= vld_q[slot_q];
			end
		end
	end

	always_comb begin
		mix_tab  = rd_vld_q ? ram_rdata : '0;
		mix_diff = $signed({2'b00, mix_tab}) - $signed({2'b00, y_q});
		mix_wrap = mix_diff;
		if (mix_diff < 33'sd1) begin
			mix_wrap = mix_diff + $signed({2'b00, MOD_A_LESS_ONE});
		end
		if (mix_wrap < 33'sd0) begin
			mix_wrap = '0;
		end
		mix_val = mix_wrap[30:0];
	end

	// ---------------- fraction, out_q * 2^24 / MOD_A ----------------
	assign frac_q0  = out_q[30:7];
	assign frac_rem = 33'({out_q[6:0], 24'd0}) + 33'(frac_q0) * 33'(FOLD_A);
	assign frac_val = ((frac_rem >= 33'(MOD_A)) && (frac_q0 != '1)) ? frac_q0 + 1'b1
	                                                               : frac_q0;

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_value_q <= out_q;
			res_frac_q  <= frac_val;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.random_value = res_value_q;
	assign res.fraction     = res_frac_q;

endmodule

// File: sv/clsg_checker.sv
// ----------------------------------------------------------------------------
// clsg_checker
// Port-level checks of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
module clsg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         req_operation,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [clsg_pkg::VAL_W-1:0]   res_random_value,
	input logic [clsg_pkg::FRAC_W-1:0]  res_fraction
);
	import clsg_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_random_value)
			&& $stable(res_fraction))
		else $error("result changed while stalled");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_random_value != '0) && (res_random_value < MOD_A))
		else $error("random value out of range");

	a_frac_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_fraction == res_random_value[30:7])
			|| (res_fraction == res_random_value[30:7] + 24'd1))
		else $error("fraction does not match random value");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_draw_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_operation |-> ##6 res_valid)
		else $error("draw result missing");

endmodule

bind combined_lcg_shuffle_generator clsg_checker u_clsg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_operation    (req.operation),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_random_value (res.random_value),
	.res_fraction     (res.fraction)
);
